// ===== rtl/tafv_pkg.sv =====
// tafv_pkg: shared types and constants for the triangle area pipeline.
// No dependencies; used by triangle_area_from_vertices, tafv_mulsat and tafv_checker.
`timescale 1ns / 1ps
`default_nettype none
package tafv_pkg;

  // Heron product limit: products at or above 2^PROD_W saturate the area
  localparam int PROD_W = 84;
  // Partial product limb of the wide multiply
  localparam int LIMB_W = 28;
  localparam int N_LIMBS = PROD_W / LIMB_W;
  // Fraction bits added to the squared distance before the side root
  localparam int FRAC_SHIFT = 8;
  // Round half up: sqrt(P) carries 10 more fraction bits than the area
  localparam int ROUND_SHIFT = 10;
  localparam int ROUND_BIAS = 512;
  localparam int AREA_W = 32;

  // Control that travels with each transaction through the multiply stages
  typedef struct packed {
    logic valid;
    logic sat;
  } pipe_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/triangle_area_from_vertices.sv =====
// triangle_area_from_vertices: Heron area of a triangle from three vertices.
// Depends on tafv_pkg, tafv_isqrt and tafv_mulsat.
//
//   channel   | signals                               | handshake
//   ----------+---------------------------------------+-----------------------
//   command   | start_i, busy_o, ax_i..cy_i            | accept: start_i & !busy_o
//   result    | valid_o, area_o                       | one-cycle strobe
//
// One transaction enters every cycle; busy_o stays low.
// The side root takes COORD_WIDTH + 5 register stages, the area root 42,
// the products six and the rest four.
// Reset clears only the valid bits and control structs; the receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module triangle_area_from_vertices #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [COORD_WIDTH-1:0] ax_i,
  input  wire logic signed [COORD_WIDTH-1:0] ay_i,
  input  wire logic signed [COORD_WIDTH-1:0] bx_i,
  input  wire logic signed [COORD_WIDTH-1:0] by_i,
  input  wire logic signed [COORD_WIDTH-1:0] cx_i,
  input  wire logic signed [COORD_WIDTH-1:0] cy_i,
  output logic                               valid_o,
  output logic [tafv_pkg::AREA_W-1:0]        area_o
);

  localparam int W    = COORD_WIDTH;
  localparam int D2W  = 2 * W + 1;
  localparam int RADW = D2W + tafv_pkg::FRAC_SHIFT;
  localparam int SDW  = (RADW + RADW % 2) / 2;
  localparam int FW   = SDW + 2;
  localparam int RTW  = tafv_pkg::PROD_W / 2;
  localparam int ROUND_SHIFT_L = tafv_pkg::ROUND_SHIFT;

  function automatic logic [W-1:0] absdiff(logic signed [W-1:0] p,
                                           logic signed [W-1:0] q);
    logic signed [W:0] d;
    logic [W:0]        m;
    d = {p[W-1], p} - {q[W-1], q};
    m = d[W] ? -d : d;
    return m[W-1:0];
  endfunction

  function automatic logic [FW-1:0] clamp_sub(logic [SDW-1:0] x, logic [SDW-1:0] y,
                                              logic [SDW-1:0] z);
    logic [SDW:0] s;
    s = (SDW+1)'(x) + (SDW+1)'(y);
    return (s > (SDW+1)'(z)) ? FW'(s - (SDW+1)'(z)) : '0;
  endfunction

  // stage registers
  logic [2:0]     vld_q;
  logic [W-1:0]   mag_q [6];
  logic [2*W-1:0] sq_q  [6];
  logic [RADW-1:0] rad_q [3];

  logic           side_vld;
  logic [SDW-1:0] side [3];

  logic           f_vld_q;
  logic [FW-1:0]  f_q [4];
  logic           zero_q;

  tafv_pkg::pipe_ctl_t m1_ctl_q;
  logic [2*FW-1:0] p01_q;
  logic [FW-1:0]   m1_f2_q, m1_f3_q;
  logic            m1_zero_q;

  tafv_pkg::pipe_ctl_t ms1_ctl, ms2_ctl;
  logic [tafv_pkg::PROD_W-1:0] ms1_x, ms2_x;
  logic [FW:0]     ms1_tag;
  logic            ms2_zero;

  logic            rt_vld;
  logic [RTW-1:0]  rt_root;
  logic            rt_sat;
  logic [RTW:0]    rsum;
  logic [RTW-ROUND_SHIFT_L:0] rshift;

  logic            out_vld_q;
  logic [tafv_pkg::AREA_W-1:0] area_q;

  assign busy_o = 1'b0;

  // advance valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  // front: magnitudes of differences, squares, squared distances
  always_ff @(posedge clk_i) begin
    mag_q[0] <= absdiff(bx_i, ax_i);
    mag_q[1] <= absdiff(by_i, ay_i);
    mag_q[2] <= absdiff(cx_i, bx_i);
    mag_q[3] <= absdiff(cy_i, by_i);
    mag_q[4] <= absdiff(cx_i, ax_i);
    mag_q[5] <= absdiff(cy_i, ay_i);
    for (int k = 0; k < 6; k++) begin
      sq_q[k] <= mag_q[k] * mag_q[k];
    end
    for (int k = 0; k < 3; k++) begin
      rad_q[k] <= {D2W'(sq_q[2*k]) + D2W'(sq_q[2*k+1]),
                   tafv_pkg::FRAC_SHIFT'(0)};
    end
  end

  // side lengths
  for (genvar k = 0; k < 3; k++) begin : g_side
    if (k == 0) begin : g_lead
      tafv_isqrt #(.IN_W(RADW), .TAG_W(1)) u_sqrt (
        .clk_i, .rst_ni,
        .valid_i(vld_q[2]), .rad_i(rad_q[k]), .tag_i(1'b0),
        .valid_o(side_vld), .root_o(side[k]), .tag_o()
      );
    end else begin : g_rest
      tafv_isqrt #(.IN_W(RADW), .TAG_W(1)) u_sqrt (
        .clk_i, .rst_ni,
        .valid_i(vld_q[2]), .rad_i(rad_q[k]), .tag_i(1'b0),
        .valid_o(), .root_o(side[k]), .tag_o()
      );
    end
  end

  // Heron factors; clamp broken triangle inequality to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q  <= 1'b0;
      m1_ctl_q <= '0;
    end else begin
      f_vld_q  <= side_vld;
      m1_ctl_q <= '{valid: f_vld_q, sat: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    f_q[0] <= FW'(side[0]) + FW'(side[1]) + FW'(side[2]);
    f_q[1] <= clamp_sub(side[1], side[2], side[0]);
    f_q[2] <= clamp_sub(side[0], side[2], side[1]);
    f_q[3] <= clamp_sub(side[0], side[1], side[2]);
    zero_q <= (clamp_sub(side[1], side[2], side[0]) == '0) ||
              (clamp_sub(side[0], side[2], side[1]) == '0) ||
              (clamp_sub(side[0], side[1], side[2]) == '0) ||
              (side[0] == '0 && side[1] == '0 && side[2] == '0);
    p01_q     <= f_q[0] * f_q[1];
    m1_f2_q   <= f_q[2];
    m1_f3_q   <= f_q[3];
    m1_zero_q <= zero_q;
  end

  // product by the third and fourth factor
  tafv_mulsat #(.FW(FW), .TAG_W(FW+1)) u_mul2 (
    .clk_i, .rst_ni,
    .ctl_i('{valid: m1_ctl_q.valid,
             sat:   (p01_q >> tafv_pkg::PROD_W) != '0}),
    .x_i(tafv_pkg::PROD_W'(p01_q)),
    .f_i(m1_f2_q),
    .tag_i({m1_zero_q, m1_f3_q}),
    .ctl_o(ms1_ctl), .x_o(ms1_x), .tag_o(ms1_tag)
  );

  tafv_mulsat #(.FW(FW), .TAG_W(1)) u_mul3 (
    .clk_i, .rst_ni,
    .ctl_i(ms1_ctl), .x_i(ms1_x), .f_i(ms1_tag[FW-1:0]), .tag_i(ms1_tag[FW]),
    .ctl_o(ms2_ctl), .x_o(ms2_x), .tag_o(ms2_zero)
  );

  // area root; a degenerate triangle never saturates
  tafv_isqrt #(.IN_W(tafv_pkg::PROD_W), .TAG_W(1)) u_area_sqrt (
    .clk_i, .rst_ni,
    .valid_i(ms2_ctl.valid), .rad_i(ms2_x), .tag_i(ms2_ctl.sat & ~ms2_zero),
    .valid_o(rt_vld), .root_o(rt_root), .tag_o(rt_sat)
  );

  // round half up to an integer area and saturate
  assign rsum   = (RTW+1)'(rt_root) + (RTW+1)'(tafv_pkg::ROUND_BIAS);
  assign rshift = rsum[RTW:ROUND_SHIFT_L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= rt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rt_sat || ((rshift >> tafv_pkg::AREA_W) != '0)) begin
      area_q <= '1;
    end else begin
      area_q <= tafv_pkg::AREA_W'(rshift);
    end
  end

  assign valid_o = out_vld_q;
  assign area_o  = area_q;

endmodule
`default_nettype wire

// ===== rtl/tafv_isqrt.sv =====
// tafv_isqrt: pipelined integer square root, one root bit per register stage.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module tafv_isqrt #(
  parameter int IN_W  = 42,
  parameter int TAG_W = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [IN_W-1:0]             rad_i,
  input  wire logic [TAG_W-1:0]            tag_i,
  output logic                             valid_o,
  output logic [(IN_W + IN_W % 2)/2-1:0]   root_o,
  output logic [TAG_W-1:0]                 tag_o
);

  localparam int RW   = IN_W + IN_W % 2;
  localparam int OW   = RW / 2;
  localparam int REMW = OW + 2;

  logic [OW-1:0]    vld_q;
  logic [RW-1:0]    rad_q  [OW];
  logic [REMW-1:0]  rem_q  [OW];
  logic [OW-1:0]    root_q [OW];
  logic [TAG_W-1:0] tag_q  [OW];

  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic             vin;
    logic [RW-1:0]    rin;
    logic [REMW-1:0]  remin;
    logic [OW-1:0]    rootin;
    logic [TAG_W-1:0] tagin;
    logic [OW+3:0]    cur;
    logic [OW+3:0]    trial;
    logic             ge;

    // select stage input: ports for the first stage, previous register otherwise
    if (k == 0) begin : g_first
      assign vin    = valid_i;
      assign rin    = RW'(rad_i);
      assign remin  = '0;
      assign rootin = '0;
      assign tagin  = tag_i;
    end else begin : g_next
      assign vin    = vld_q[k-1];
      assign rin    = rad_q[k-1];
      assign remin  = rem_q[k-1];
      assign rootin = root_q[k-1];
      assign tagin  = tag_q[k-1];
    end

    // trial subtract of the next two radicand bits
    assign cur   = {remin, rin[RW-1 -: 2]};
    assign trial = {2'b00, rootin, 2'b01};
    assign ge    = cur >= trial;

    // advance valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    // advance payload
    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rin << 2;
      rem_q[k]  <= ge ? REMW'(cur - trial) : REMW'(cur);
      root_q[k] <= {rootin[OW-2:0], ge};
      tag_q[k]  <= tagin;
    end
  end

  assign valid_o = vld_q[OW-1];
  assign root_o  = root_q[OW-1];
  assign tag_o   = tag_q[OW-1];

endmodule
`default_nettype wire

// ===== rtl/tafv_mulsat.sv =====
// tafv_mulsat: two-stage multiply of a saturating wide product by one factor.
// Depends on tafv_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none
module tafv_mulsat #(
  parameter int FW    = 23,
  parameter int TAG_W = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tafv_pkg::pipe_ctl_t         ctl_i,
  input  wire logic [tafv_pkg::PROD_W-1:0] x_i,
  input  wire logic [FW-1:0]               f_i,
  input  wire logic [TAG_W-1:0]            tag_i,
  output tafv_pkg::pipe_ctl_t              ctl_o,
  output logic [tafv_pkg::PROD_W-1:0]      x_o,
  output logic [TAG_W-1:0]                 tag_o
);

  localparam int PPW = tafv_pkg::LIMB_W + FW;
  localparam int SW  = tafv_pkg::PROD_W + FW;

  tafv_pkg::pipe_ctl_t ctl_a_q, ctl_b_q;
  logic [PPW-1:0]      pp_q [tafv_pkg::N_LIMBS];
  logic [TAG_W-1:0]    tag_a_q, tag_b_q;
  logic [tafv_pkg::PROD_W-1:0] x_b_q;
  logic [SW-1:0]       acc;

  // hold control through both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= '{valid: ctl_a_q.valid,
                   sat:   ctl_a_q.sat | ((acc >> tafv_pkg::PROD_W) != '0)};
    end
  end

  // stage A: one partial product per limb
  for (genvar j = 0; j < tafv_pkg::N_LIMBS; j++) begin : g_limb
    always_ff @(posedge clk_i) begin
      pp_q[j] <= x_i[j*tafv_pkg::LIMB_W +: tafv_pkg::LIMB_W] * f_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_a_q <= tag_i;
  end

  // stage B: align and sum partial products
  always_comb begin
    acc = '0;
    for (int j = 0; j < tafv_pkg::N_LIMBS; j++) begin
      acc = acc + (SW'(pp_q[j]) << (j * tafv_pkg::LIMB_W));
    end
  end

  always_ff @(posedge clk_i) begin
    x_b_q   <= tafv_pkg::PROD_W'(acc);
    tag_b_q <= tag_a_q;
  end

  assign ctl_o = ctl_b_q;
  assign x_o   = x_b_q;
  assign tag_o = tag_b_q;

endmodule
`default_nettype wire

// ===== rtl/tafv_checker.sv =====
// tafv_checker: port-level checks for triangle_area_from_vertices, bound in.
// Depends on tafv_pkg for the area width.
`timescale 1ns / 1ps
`default_nettype none
module tafv_checker #(
  parameter int COORD_WIDTH = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          busy_o,
  input wire logic signed [COORD_WIDTH-1:0] ax_i,
  input wire logic signed [COORD_WIDTH-1:0] ay_i,
  input wire logic signed [COORD_WIDTH-1:0] bx_i,
  input wire logic signed [COORD_WIDTH-1:0] by_i,
  input wire logic                          valid_o,
  input wire logic [tafv_pkg::AREA_W-1:0]   area_o
);

  localparam int LAT = COORD_WIDTH + 57;

  // the block never refuses a transaction
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy asserted");

  // each accepted transaction yields a result
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT valid_o) else $error("result missing");

  // no result without a transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##LAT !valid_o) else $error("spurious result");

  // coincident vertices a and b give zero area
  a_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && ax_i == bx_i && ay_i == by_i) |-> ##LAT
    (valid_o && area_o == '0)) else $error("degenerate area not zero");

endmodule

bind triangle_area_from_vertices tafv_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tafv_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .ax_i, .ay_i, .bx_i, .by_i, .valid_o, .area_o
);
`default_nettype wire
